### rtl/s2je_pkg.sv
// Shared types and constants for the 2x2 symmetric Jacobi eigen block.
// No dependencies; imported by every module of the block.
package s2je_pkg;

    localparam int DATA_W     = 32;
    localparam int TOL_W      = 31;
    localparam int EIG_W      = DATA_W + 1;
    localparam int TRIG_FRAC  = 30;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // one square-root digit step: remainder and partial root
    typedef struct packed {
        logic        valid;
        logic [63:0] n;
        logic [63:0] res;
    } root_st_t;

    // one restoring-division step: partial remainder, dividend bits still to
    // shift in, divisor, quotient so far
    typedef struct packed {
        logic        valid;
        logic [32:0] rem;
        logic [30:0] num;
        logic [32:0] den;
        logic [30:0] quo;
    } div_st_t;

    // per-transaction data that rides alongside the arithmetic chains
    typedef struct packed {
        logic signed [DATA_W-1:0] d1;
        logic signed [DATA_W-1:0] d2;
        logic [31:0]              mag;
        logic                     rot;
        logic                     t_neg;
        logic                     diff_neg;
    } side_t;

endpackage

### rtl/s2je_root_cell.sv
// One registered digit step of a floor square root (one result bit per cell).
// Depends on s2je_pkg.
module s2je_root_cell
    import s2je_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic [4:0] step,
    input  root_st_t d_in,
    output root_st_t d_out
);

    logic        valid_reg;
    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bitv;
    logic [63:0] trial;

    always_comb
    begin
        bitv  = 64'd1 << {step, 1'b0};
        trial = d_in.res + bitv;
        if (d_in.n >= trial)
        begin
            n_next   = d_in.n - trial;
            res_next = (d_in.res >> 1) + bitv;
        end
        else
        begin
            n_next   = d_in.n;
            res_next = d_in.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= d_in.valid;
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
    end

    assign d_out = '{valid: valid_reg, n: n_reg, res: res_reg};

endmodule

### rtl/s2je_div_cell.sv
// One registered restoring-division step (one quotient bit per cell).
// Depends on s2je_pkg.
module s2je_div_cell
    import s2je_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  div_st_t d_in,
    output div_st_t d_out
);

    logic        valid_reg;
    logic [32:0] rem_reg, rem_next;
    logic [30:0] num_reg;
    logic [32:0] den_reg;
    logic [30:0] quo_reg;
    logic [33:0] rem2;
    logic        ge;

    always_comb
    begin
        rem2 = {d_in.rem, d_in.num[30]};
        ge   = (rem2 >= {1'b0, d_in.den});
        if (ge)
            rem_next = 33'(rem2 - {1'b0, d_in.den});
        else
            rem_next = rem2[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= d_in.valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= {d_in.num[29:0], 1'b0};
        den_reg <= d_in.den;
        quo_reg <= {d_in.quo[29:0], ge};
    end

    assign d_out = '{valid: valid_reg, rem: rem_reg, num: num_reg, den: den_reg,
                     quo: quo_reg};

endmodule

### rtl/sym2x2_jacobi_eigen_top.sv
// Top level of the 2x2 symmetric Jacobi eigen block: front end, four cell chains, back end.
// Depends on s2je_pkg, s2je_root_cell and s2je_div_cell.
//
// Usage:
//   Input: drive diag_first, off_diag, diag_second and pulse start. busy is always low,
//   so a new matrix may be started every clock cycle.
//   Config: tolerance_we writes tolerance (Q16.16 off-diagonal threshold); the user must
//   write it only while no transaction is in flight, as the block does not enforce this.
//   Output: done is high for exactly one cycle with eigen_first, eigen_second, cosine,
//   sine and rotated valid. The receiver cannot stall; results are never held.
//   Pipeline: 135 register stages between start and done.
//   Throughput: one matrix per cycle. The stages are the chains of cells:
//   two 32-cell square-root chains and two 31-cell division chains, one bit each,
//   plus nine pipeline registers for input, squaring, sum of squares, tangent and cosine
//   divide setups, clamp and products, the sine product and the output.
//   Reset: rst_n clears all valid bits and the tolerance (to 0); transactions in
//   flight are dropped.
module sym2x2_jacobi_eigen_top
    import s2je_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] diag_first,
    input  logic signed [DATA_W-1:0] off_diag,
    input  logic signed [DATA_W-1:0] diag_second,
    input  logic                     tolerance_we,
    input  logic [TOL_W-1:0]         tolerance,
    output logic                     done,
    output logic signed [EIG_W-1:0]  eigen_first,
    output logic signed [EIG_W-1:0]  eigen_second,
    output logic [30:0]              cosine,
    output logic signed [31:0]       sine,
    output logic                     rotated
);

    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (tolerance_we)
            tol_reg <= tolerance;
    end

    assign busy = 1'b0;

    // ---------------- front end ----------------
    logic [32:0] a_ext, mag_ext;
    logic [31:0] mag_c;
    logic [32:0] diff;
    logic [32:0] dm_c, em_c;
    logic [30:0] dm_s, em_s;
    side_t       side_c;

    always_comb
    begin
        a_ext   = {off_diag[DATA_W-1], off_diag};
        mag_ext = a_ext[32] ? 33'(-a_ext) : a_ext;
        mag_c   = mag_ext[31:0];
        diff    = 33'({diag_second[DATA_W-1], diag_second} - {diag_first[DATA_W-1], diag_first});
        dm_c    = diff[32] ? 33'(-diff) : diff;
        em_c    = {mag_c, 1'b0};
        priority if (dm_c[32] || em_c[32])
        begin
            dm_s = dm_c[32:2];
            em_s = em_c[32:2];
        end
        else if (dm_c[31] || em_c[31])
        begin
            dm_s = dm_c[31:1];
            em_s = em_c[31:1];
        end
        else
        begin
            dm_s = dm_c[30:0];
            em_s = em_c[30:0];
        end
        side_c.d1       = diag_first;
        side_c.d2       = diag_second;
        side_c.mag      = mag_c;
        side_c.rot      = (mag_c > {1'b0, tol_reg});
        side_c.t_neg    = off_diag[DATA_W-1] != diff[32];
        side_c.diff_neg = diff[32];
    end

    logic        v0_reg, v1_reg, v2_reg;
    logic [30:0] dm0_reg, em0_reg, dm1_reg, em1_reg, dm2_reg, em2_reg;
    logic [61:0] sqd_reg, sqe_reg;
    logic [62:0] nrad_reg;
    side_t       side0_reg, side1_reg, side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start & ~busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dm0_reg   <= dm_s;
        em0_reg   <= em_s;
        side0_reg <= side_c;
        sqd_reg   <= dm0_reg * dm0_reg;
        sqe_reg   <= em0_reg * em0_reg;
        dm1_reg   <= dm0_reg;
        em1_reg   <= em0_reg;
        side1_reg <= side0_reg;
        nrad_reg  <= {1'b0, sqd_reg} + {1'b0, sqe_reg};
        dm2_reg   <= dm1_reg;
        em2_reg   <= em1_reg;
        side2_reg <= side1_reg;
    end

    // ---------------- first root chain: R = floor(sqrt(D^2 + E^2)) ----------------
    root_st_t root1_st [0:ROOT_STEPS];
    side_t    r1_side  [0:ROOT_STEPS-1];
    logic [30:0] r1_dm [0:ROOT_STEPS-1];
    logic [30:0] r1_em [0:ROOT_STEPS-1];

    assign root1_st[0] = '{valid: v2_reg, n: {1'b0, nrad_reg}, res: 64'd0};

    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root1
        s2je_root_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (5'(ROOT_STEPS - 1 - i)),
            .d_in  (root1_st[i]),
            .d_out (root1_st[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        r1_side[0] <= side2_reg;
        r1_dm[0]   <= dm2_reg;
        r1_em[0]   <= em2_reg;
        for (int k = 1; k < ROOT_STEPS; k++)
        begin
            r1_side[k] <= r1_side[k-1];
            r1_dm[k]   <= r1_dm[k-1];
            r1_em[k]   <= r1_em[k-1];
        end
    end

    // ---------------- tangent divide setup ----------------
    logic [32:0] den1_c;
    logic [61:0] num1_c;
    logic        dv1_reg;
    div_st_t     div1_in_reg;
    side_t       side3_reg;

    always_comb
    begin
        den1_c = {2'b00, r1_dm[ROOT_STEPS-1]} + {1'b0, root1_st[ROOT_STEPS].res[31:0]};
        if (den1_c == 33'd0)
            den1_c = 33'd1;
        num1_c = {1'b0, r1_em[ROOT_STEPS-1], 30'd0} + {29'd0, den1_c[32:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv1_reg <= 1'b0;
        else
            dv1_reg <= root1_st[ROOT_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        div1_in_reg.rem <= {2'b00, num1_c[61:31]};
        div1_in_reg.num <= num1_c[30:0];
        div1_in_reg.den <= den1_c;
        div1_in_reg.quo <= '0;
        side3_reg       <= r1_side[ROOT_STEPS-1];
    end

    // ---------------- first division chain: |t| ----------------
    div_st_t div1_st [0:DIV_STEPS];
    side_t   d1_side [0:DIV_STEPS-1];

    assign div1_st[0] = '{valid: dv1_reg, rem: div1_in_reg.rem, num: div1_in_reg.num,
                          den: div1_in_reg.den, quo: div1_in_reg.quo};

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div1
        s2je_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .d_in  (div1_st[i]),
            .d_out (div1_st[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        d1_side[0] <= side3_reg;
        for (int k = 1; k < DIV_STEPS; k++)
            d1_side[k] <= d1_side[k-1];
    end

    // ---------------- t clamp, t^2, |a|*t ----------------
    localparam logic [30:0] ONE_Q30 = 31'(64'd1 << TRIG_FRAC);
    localparam logic [61:0] ONE_Q60 = 62'(64'd1 << (2 * TRIG_FRAC));

    logic [30:0] t_c;
    logic        v4_reg, v5_reg;
    logic [30:0] t4_reg, t5_reg;
    logic [61:0] t2_reg;
    logic [62:0] pr4_reg;
    logic [61:0] rad2_reg;
    logic [32:0] prod5_reg;
    side_t       side4_reg, side5_reg;

    assign t_c = (div1_st[DIV_STEPS].quo > ONE_Q30) ? ONE_Q30 : div1_st[DIV_STEPS].quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= div1_st[DIV_STEPS].valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t4_reg    <= t_c;
        t2_reg    <= t_c * t_c;
        pr4_reg   <= d1_side[DIV_STEPS-1].mag * t_c;
        side4_reg <= d1_side[DIV_STEPS-1];
        t5_reg    <= t4_reg;
        rad2_reg  <= ONE_Q60 + t2_reg;
        prod5_reg <= 33'((pr4_reg + 63'(64'd1 << (TRIG_FRAC - 1))) >> TRIG_FRAC);
        side5_reg <= side4_reg;
    end

    // ---------------- second root chain: sqrt(2^60 + t^2) ----------------
    root_st_t    root2_st [0:ROOT_STEPS];
    side_t       r2_side  [0:ROOT_STEPS-1];
    logic [30:0] r2_t     [0:ROOT_STEPS-1];
    logic [32:0] r2_prod  [0:ROOT_STEPS-1];

    assign root2_st[0] = '{valid: v5_reg, n: {2'b00, rad2_reg}, res: 64'd0};

    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root2
        s2je_root_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (5'(ROOT_STEPS - 1 - i)),
            .d_in  (root2_st[i]),
            .d_out (root2_st[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        r2_side[0] <= side5_reg;
        r2_t[0]    <= t5_reg;
        r2_prod[0] <= prod5_reg;
        for (int k = 1; k < ROOT_STEPS; k++)
        begin
            r2_side[k] <= r2_side[k-1];
            r2_t[k]    <= r2_t[k-1];
            r2_prod[k] <= r2_prod[k-1];
        end
    end

    // ---------------- cosine divide setup ----------------
    logic [31:0] root_u;
    logic [61:0] num2_c;
    logic        dv2_reg;
    div_st_t     div2_in_reg;
    side_t       side6_reg;
    logic [30:0] t6_reg;
    logic [32:0] prod6_reg;

    assign root_u = root2_st[ROOT_STEPS].res[31:0];
    assign num2_c = ONE_Q60 + {31'd0, root_u[31:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv2_reg <= 1'b0;
        else
            dv2_reg <= root2_st[ROOT_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        div2_in_reg.rem <= {2'b00, num2_c[61:31]};
        div2_in_reg.num <= num2_c[30:0];
        div2_in_reg.den <= {1'b0, root_u};
        div2_in_reg.quo <= '0;
        side6_reg       <= r2_side[ROOT_STEPS-1];
        t6_reg          <= r2_t[ROOT_STEPS-1];
        prod6_reg       <= r2_prod[ROOT_STEPS-1];
    end

    // ---------------- second division chain: cosine ----------------
    div_st_t     div2_st [0:DIV_STEPS];
    side_t       d2_side [0:DIV_STEPS-1];
    logic [30:0] d2_t    [0:DIV_STEPS-1];
    logic [32:0] d2_prod [0:DIV_STEPS-1];

    assign div2_st[0] = '{valid: dv2_reg, rem: div2_in_reg.rem, num: div2_in_reg.num,
                          den: div2_in_reg.den, quo: div2_in_reg.quo};

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div2
        s2je_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .d_in  (div2_st[i]),
            .d_out (div2_st[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        d2_side[0] <= side6_reg;
        d2_t[0]    <= t6_reg;
        d2_prod[0] <= prod6_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            d2_side[k] <= d2_side[k-1];
            d2_t[k]    <= d2_t[k-1];
            d2_prod[k] <= d2_prod[k-1];
        end
    end

    // ---------------- sine product ----------------
    logic        v7_reg;
    logic [30:0] cos7_reg;
    logic [61:0] tc7_reg;
    logic [32:0] prod7_reg;
    side_t       side7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= div2_st[DIV_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        cos7_reg  <= div2_st[DIV_STEPS].quo;
        tc7_reg   <= d2_t[DIV_STEPS-1] * div2_st[DIV_STEPS].quo;
        prod7_reg <= d2_prod[DIV_STEPS-1];
        side7_reg <= d2_side[DIV_STEPS-1];
    end

    // ---------------- back end: signs, eigenvalues, saturation ----------------
    localparam logic signed [33:0] EIG_MAX = 34'sd4294967295;
    localparam logic signed [33:0] EIG_MIN = -34'sd4294967296;

    logic [31:0]        sm_c;
    logic signed [31:0] sin_c;
    logic signed [33:0] d1x, d2x, px, e1_c, e2_c;
    logic signed [EIG_W-1:0] e1_sat, e2_sat;

    always_comb
    begin
        sm_c  = 32'((tc7_reg + 62'(64'd1 << (TRIG_FRAC - 1))) >> TRIG_FRAC);
        sin_c = side7_reg.t_neg ? 32'(-sm_c) : sm_c;
        d1x   = 34'(side7_reg.d1);
        d2x   = 34'(side7_reg.d2);
        px    = {1'b0, prod7_reg};
        if (!side7_reg.rot)
        begin
            e1_c = d1x;
            e2_c = d2x;
        end
        else if (side7_reg.diff_neg)
        begin
            e1_c = d1x + px;
            e2_c = d2x - px;
        end
        else
        begin
            e1_c = d1x - px;
            e2_c = d2x + px;
        end
        priority if (e1_c > EIG_MAX)
            e1_sat = EIG_MAX[EIG_W-1:0];
        else if (e1_c < EIG_MIN)
            e1_sat = EIG_MIN[EIG_W-1:0];
        else
            e1_sat = e1_c[EIG_W-1:0];
        priority if (e2_c > EIG_MAX)
            e2_sat = EIG_MAX[EIG_W-1:0];
        else if (e2_c < EIG_MIN)
            e2_sat = EIG_MIN[EIG_W-1:0];
        else
            e2_sat = e2_c[EIG_W-1:0];
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        eigen_first  <= e1_sat;
        eigen_second <= e2_sat;
        rotated      <= side7_reg.rot;
        cosine       <= side7_reg.rot ? cos7_reg : ONE_Q30;
        sine         <= side7_reg.rot ? sin_c : 32'sd0;
    end

    assign done = done_reg;

endmodule

### sim/s2je_checker.sv
// Checker for the 2x2 symmetric Jacobi eigen block: watches input, config and result
// channels, predicts each result, and compares it field by field. Depends on s2je_pkg.
module s2je_checker
    import s2je_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [DATA_W-1:0] diag_first,
    input  logic signed [DATA_W-1:0] off_diag,
    input  logic signed [DATA_W-1:0] diag_second,
    input  logic                     tolerance_we,
    input  logic [TOL_W-1:0]         tolerance,
    input  logic                     done,
    input  logic signed [EIG_W-1:0]  eigen_first,
    input  logic signed [EIG_W-1:0]  eigen_second,
    input  logic [30:0]              cosine,
    input  logic signed [31:0]       sine,
    input  logic                     rotated,
    output int                       errors,
    output int                       in_flight,
    output int                       rotated_seen,
    output int                       passed_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [EIG_W-1:0] e1;
        logic signed [EIG_W-1:0] e2;
        logic [30:0]             cs;
        logic signed [31:0]      sn;
        logic                    rot;
    } eigen_res_t;

    eigen_res_t          eigen_q[$];
    logic [TOL_W-1:0]    tol_copy;

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint clamp_eig(input longint v);
        longint hi;
        hi = (longint'(1) <<< (EIG_W - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic eigen_res_t jacobi_rotate(input logic signed [DATA_W-1:0] d1_in,
                                                 input logic signed [DATA_W-1:0] a_in,
                                                 input logic signed [DATA_W-1:0] d2_in,
                                                 input logic [TOL_W-1:0] tol);
        eigen_res_t      r;
        longint          d1, a, d2, diff, e1, e2;
        longint unsigned mag, dm, em, rt, den, t, ru, cs, sm, prod;
        logic            diff_neg, t_neg;
        d1 = longint'(d1_in);
        a = longint'(a_in);
        d2 = longint'(d2_in);
        mag = (a < 0) ? longint'(-a) : longint'(a);
        e1 = d1;
        e2 = d2;
        r.cs = 31'd1 << TRIG_FRAC;
        r.sn = '0;
        r.rot = 1'b0;
        if (mag > longint'(tol)) begin
            diff = d2 - d1;
            diff_neg = diff < 0;
            dm = diff_neg ? -diff : diff;
            em = mag << 1;
            t_neg = (a < 0) != diff_neg;
            while (dm >= (64'd1 << 31) || em >= (64'd1 << 31)) begin
                dm = dm >> 1;
                em = em >> 1;
            end
            rt = isqrt(dm * dm + em * em);
            den = dm + rt;
            if (den == 0)
                den = 1;
            t = ((em << TRIG_FRAC) + (den >> 1)) / den;
            if (t > (64'd1 << TRIG_FRAC))
                t = 64'd1 << TRIG_FRAC;
            ru = isqrt((64'd1 << (2 * TRIG_FRAC)) + t * t);
            cs = ((64'd1 << (2 * TRIG_FRAC)) + (ru >> 1)) / ru;
            sm = (t * cs + (64'd1 << (TRIG_FRAC - 1))) >> TRIG_FRAC;
            prod = (mag * t + (64'd1 << (TRIG_FRAC - 1))) >> TRIG_FRAC;
            if (diff_neg) begin
                e1 = d1 + longint'(prod);
                e2 = d2 - longint'(prod);
            end
            else begin
                e1 = d1 - longint'(prod);
                e2 = d2 + longint'(prod);
            end
            r.cs = cs[30:0];
            r.sn = 32'(t_neg ? -longint'(sm) : longint'(sm));
            r.rot = 1'b1;
        end
        r.e1 = EIG_W'(clamp_eig(e1));
        r.e2 = EIG_W'(clamp_eig(e2));
        return r;
    endfunction

    // sample mid-cycle: inputs were driven at the rising edge, results hold a full cycle
    always @(negedge clk or negedge rst_n) begin
        eigen_res_t want;
        if (!rst_n) begin
            eigen_q.delete();
            in_flight = 0;
            tol_copy = '0;
            errors = 0;
            rotated_seen = 0;
            passed_seen = 0;
        end
        else begin
            if (tolerance_we)
                tol_copy = tolerance;
            if (start && !busy)
                eigen_q.push_back(jacobi_rotate(diag_first, off_diag, diag_second,
                                                tol_copy));
            if (done) begin
                if (eigen_q.size() == 0) begin
                    $display("%t: unexpected result transaction", $realtime);
                    errors++;
                end
                else begin
                    want = eigen_q.pop_front();
                    if (rotated)
                        rotated_seen++;
                    else
                        passed_seen++;
                    if (eigen_first !== want.e1) begin
                        $display("%t: eigen_first exp %0d got %0d", $realtime, want.e1,
                                 eigen_first);
                        errors++;
                    end
                    if (eigen_second !== want.e2) begin
                        $display("%t: eigen_second exp %0d got %0d", $realtime, want.e2,
                                 eigen_second);
                        errors++;
                    end
                    if (cosine !== want.cs) begin
                        $display("%t: cosine exp %0d got %0d", $realtime, want.cs, cosine);
                        errors++;
                    end
                    if (sine !== want.sn) begin
                        $display("%t: sine exp %0d got %0d", $realtime, want.sn, sine);
                        errors++;
                    end
                    if (rotated !== want.rot) begin
                        $display("%t: rotated exp %0d got %0d", $realtime, want.rot, rotated);
                        errors++;
                    end
                end
            end
            in_flight = eigen_q.size();
        end
    end

endmodule

### sim/sym2x2_jacobi_eigen_top_test.sv
// Testbench top for sym2x2_jacobi_eigen_top: clock, reset, stimulus and verdict.
// Depends on s2je_pkg, the block's RTL and s2je_checker.
module sym2x2_jacobi_eigen_top_test;
    import s2je_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1430;
    localparam int LATENCY   = 135;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] diag_first;
    logic signed [DATA_W-1:0] off_diag;
    logic signed [DATA_W-1:0] diag_second;
    logic                     tolerance_we;
    logic [TOL_W-1:0]         tolerance;
    logic                     done;
    logic signed [EIG_W-1:0]  eigen_first;
    logic signed [EIG_W-1:0]  eigen_second;
    logic [30:0]              cosine;
    logic signed [31:0]       sine;
    logic                     rotated;
    int                       errors;
    int                       in_flight;
    int                       rotated_seen;
    int                       passed_seen;
    int                       n_sent;
    int                       n_tol;

    sym2x2_jacobi_eigen_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .diag_first(diag_first), .off_diag(off_diag), .diag_second(diag_second),
        .tolerance_we(tolerance_we), .tolerance(tolerance), .done(done),
        .eigen_first(eigen_first), .eigen_second(eigen_second), .cosine(cosine),
        .sine(sine), .rotated(rotated)
    );

    s2je_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .diag_first(diag_first), .off_diag(off_diag), .diag_second(diag_second),
        .tolerance_we(tolerance_we), .tolerance(tolerance), .done(done),
        .eigen_first(eigen_first), .eigen_second(eigen_second), .cosine(cosine),
        .sine(sine), .rotated(rotated), .errors(errors), .in_flight(in_flight),
        .rotated_seen(rotated_seen), .passed_seen(passed_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #4ms;
        $display("** sym2x2_jacobi_eigen_top: FAILED **");
        $finish;
    end

    // present one matrix and hold it until the edge that takes it
    task automatic send_matrix(input logic [31:0] d1, input logic [31:0] a,
                               input logic [31:0] d2);
        logic was_busy;
        start <= 1'b1;
        diag_first <= d1;
        off_diag <= a;
        diag_second <= d2;
        do begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end while (was_busy);
        n_sent++;
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    // only called with nothing in flight
    task automatic set_tolerance(input logic [TOL_W-1:0] v);
        tolerance_we <= 1'b1;
        tolerance <= v;
        @(posedge clk);
        tolerance_we <= 1'b0;
        @(posedge clk);
        n_tol++;
    endtask

    function automatic logic [31:0] pick_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic random_phase(input int n, input bit gaps);
        logic [31:0] d1, a, d2;
        int          mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            d1 = pick_value(mode < 5 ? 0 : mode % 4);
            a = pick_value($urandom_range(0, 3));
            d2 = ($urandom_range(0, 7) == 0) ? d1 : pick_value($urandom_range(0, 3));
            send_matrix(d1, a, d2);
            if (gaps && $urandom_range(0, 5) == 0)
                idle_cycles($urandom_range(1, 12));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        diag_first = '0;
        off_diag = '0;
        diag_second = '0;
        tolerance_we = 1'b0;
        tolerance = '0;
        n_sent = 0;
        n_tol = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero tolerance, extremes, equal diagonals, signs
        send_matrix(32'h0, 32'h0, 32'h0);
        send_matrix(32'h0001_0000, 32'h0000_0001, 32'h0001_0000);
        send_matrix(32'h0002_0000, 32'hffff_0000, 32'h0002_0000);
        send_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_matrix(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_matrix(32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
        send_matrix(32'h0001_0000, 32'hffff_0000, 32'h0003_0000);
        send_matrix(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000);
        send_matrix(32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000);
        idle_cycles(3);
        drain();
        set_tolerance(31'h7fff_ffff);
        send_matrix(32'h0001_0000, 32'h8000_0000, 32'h0002_0000);
        send_matrix(32'h0001_0000, 32'h7fff_ffff, 32'h0002_0000);
        send_matrix(32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff);
        drain();
        set_tolerance(31'h0001_0000);
        send_matrix(32'h0001_0000, 32'h0001_0000, 32'h0005_0000);
        send_matrix(32'h0001_0000, 32'hffff_0000, 32'h0005_0000);
        send_matrix(32'h0001_0000, 32'h0001_0001, 32'h0005_0000);
        send_matrix(32'h0001_0000, 32'hfffe_ffff, 32'h0005_0000);
        drain();
        set_tolerance('0);

        random_phase(N_RANDOM / 4, 1'b1);
        drain();
        set_tolerance(31'h0000_8000);
        random_phase(N_RANDOM / 4, 1'b1);
        drain();
        set_tolerance(31'($urandom_range(0, 32'h7fff_ffff)));
        random_phase(N_RANDOM / 8, 1'b1);
        drain();
        set_tolerance(31'h7fff_ffff);
        random_phase(N_RANDOM / 16, 1'b1);
        drain();
        set_tolerance(31'($urandom_range(0, 1 << 20)));
        random_phase(N_RANDOM / 8, 1'b1);
        // sender waits for the pipeline to empty mid-phase
        drain();
        random_phase(N_RANDOM / 16, 1'b1);
        drain();
        set_tolerance('0);
        random_phase(N_RANDOM / 8, 1'b0);

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d matrices under %0d tolerance settings.", n_sent, n_tol);
        $display("Results: %0d rotated, %0d passed through.", rotated_seen, passed_seen);
        if (errors == 0 && in_flight == 0)
            $display("** sym2x2_jacobi_eigen_top: PASSED **");
        else
            $display("** sym2x2_jacobi_eigen_top: FAILED **");
        $finish;
    end

endmodule
